// ===== sv/cis_pkg.sv =====
// Shared types and constants for the cumulative interval search core.
// No dependencies; imported by every module of the block.
`default_nettype none

package cis_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_VALUE_BITS  = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [9:0]  entry_index;
		logic [31:0] entry_value;
		logic [31:0] search_value;
		logic [9:0]  low_bound;
		logic [9:0]  high_bound;
	} cis_req_t;

	typedef struct packed {
		logic       found;
		logic [9:0] position;
	} cis_res_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_SEARCH,
		OP_MISS
	} cis_op_t;

	// idx_a: write index or low bound; idx_b: high bound
	typedef struct packed {
		cis_op_t     op;
		logic [9:0]  idx_a;
		logic [9:0]  idx_b;
		logic [31:0] data;
	} cis_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TOTAL,
		ST_SCAN
	} cis_state_t;

endpackage

`default_nettype wire

// ===== sv/cumulative_interval_search_core.sv =====
// Cumulative interval search core: top level joining front stage, queue and engine.
// Depends on cis_pkg, cis_front, cis_queue, cis_back.
//
// Usage: requests arrive on req_valid/req_ready/req_data. A write request
// (req_type = 0) stores entry_value at entry_index and gives no result; an
// index past the table is dropped. A search request (req_type = 1) gives one
// result beat on res_valid/res_ready/res_data: found and position of the
// first entry after low_bound whose value exceeds search_value, or not found
// when bounds are bad or the value is not below the entry at high_bound.
// A command is registered in the front stage, then in the queue, then reaches
// the engine. A write is stored without waiting on the result register. A
// search reads the total at high_bound, then scans upward one table entry per
// cycle through the single read port until a hit loads the result register; a
// search rejected in the front stage or by the total check gives not found.
// Reset clears the pipeline and queue control only; table entries are
// undefined until written, and searches must only touch written entries.
// If res_ready stays low, the result register holds, the engine waits, and
// the queue and front stage fill before req_ready drops.
`default_nettype none

module cumulative_interval_search_core import cis_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire cis_req_t req_data,
	output logic          res_valid,
	input  wire logic     res_ready,
	output cis_res_t      res_data
);

	logic     f_valid;
	logic     f_ready;
	cis_cmd_t f_cmd;
	logic     b_valid;
	logic     b_ready;
	cis_cmd_t b_cmd;

	cis_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_data  (f_cmd)
	);

	cis_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_cmd)
	);

	cis_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd_data  (b_cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire

// ===== sv/cis_front.sv =====
// Front stage: accepts requests, checks bounds and classifies them into commands.
// Depends on cis_pkg.
`default_nettype none

module cis_front import cis_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire cis_req_t req_data,
	output logic          cmd_valid,
	input  wire logic     cmd_ready,
	output cis_cmd_t      cmd_data
);

	logic     cmd_valid_q;
	cis_cmd_t cmd_q;
	cis_cmd_t cmd_d;
	logic     keep;
	logic     lo_bad;
	logic     hi_bad;
	logic     wr_bad;

	assign req_ready = !cmd_valid_q || cmd_ready;
	assign cmd_valid = cmd_valid_q;
	assign cmd_data  = cmd_q;

	assign wr_bad = 32'(req_data.entry_index) >= TABLE_DEPTH;
	assign lo_bad = 32'(req_data.low_bound) >= TABLE_DEPTH;
	assign hi_bad = 32'(req_data.high_bound) >= TABLE_DEPTH;

	always_comb begin
		cmd_d = '0;
		keep  = 1'b1;
		if (req_data.req_type == REQ_WRITE) begin
			cmd_d.op    = OP_WRITE;
			cmd_d.idx_a = req_data.entry_index;
			cmd_d.data  = req_data.entry_value;
			keep        = !wr_bad;   // out-of-range writes are dropped
		end else begin
			cmd_d.idx_a = req_data.low_bound;
			cmd_d.idx_b = req_data.high_bound;
			cmd_d.data  = req_data.search_value;
			if (lo_bad || hi_bad || req_data.low_bound >= req_data.high_bound) begin
				cmd_d.op = OP_MISS;
			end else begin
				cmd_d.op = OP_SEARCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (req_ready) begin
			cmd_valid_q <= req_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			cmd_q <= cmd_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/cis_queue.sv =====
// Short command queue between the front stage and the search engine.
// Depends on cis_pkg.
`default_nettype none

module cis_queue import cis_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire cis_cmd_t push_data,
	output logic          pop_valid,
	input  wire logic     pop_ready,
	output cis_cmd_t      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cis_cmd_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== sv/cis_back.sv =====
// Search engine: owns the cumulative table, executes writes and scans for searches,
// and holds the result register. Depends on cis_pkg.
`default_nettype none

module cis_back import cis_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_ready,
	input  wire cis_cmd_t cmd_data,
	output logic          res_valid,
	input  wire logic     res_ready,
	output cis_res_t      res_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [VALUE_BITS-1:0] table_mem [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] rdata_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [AW-1:0]         addr_q;

	cis_state_t state_q;
	cis_state_t state_d;

	logic                  res_valid_q;
	cis_res_t              res_q;
	logic                  slot_free;

	logic                  wr_en;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  start;
	logic                  load_res;
	cis_res_t              res_d;
	logic                  total_miss;
	logic                  hit;
	logic [AW-1:0]         step_addr;

	assign slot_free  = !res_valid_q || res_ready;
	assign res_valid  = res_valid_q;
	assign res_data   = res_q;
	assign total_miss = (rdata_q == '0) || (value_q >= rdata_q);
	assign hit        = value_q < rdata_q;
	assign step_addr  = addr_q + AW'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd_data.op == OP_SEARCH) begin
					state_d = ST_TOTAL;
				end
			end
			ST_TOTAL: begin
				if (!total_miss) begin
					state_d = ST_SCAN;
				end else if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (hit && slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = step_addr;
		start     = 1'b0;
		load_res  = 1'b0;
		res_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd_data.op)
						OP_WRITE: begin
							wr_en     = 1'b1;
							cmd_ready = 1'b1;
						end
						OP_SEARCH: begin
							// fetch the total at the high bound first
							rd_en     = 1'b1;
							rd_addr   = AW'(cmd_data.idx_b);
							start     = 1'b1;
							cmd_ready = 1'b1;
						end
						OP_MISS: begin
							load_res  = slot_free;
							cmd_ready = slot_free;
						end
						default: cmd_ready = 1'b1;
					endcase
				end
			end
			ST_TOTAL: begin
				if (!total_miss) begin
					rd_en = 1'b1;
				end else begin
					load_res = slot_free;
				end
			end
			ST_SCAN: begin
				// entry at the high bound exceeds the value, so the scan ends there at latest
				if (hit) begin
					load_res       = slot_free;
					res_d.found    = 1'b1;
					res_d.position = 10'(addr_q);
				end else begin
					rd_en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[AW'(cmd_data.idx_a)] <= VALUE_BITS'(cmd_data.data);
		end
		if (rd_en) begin
			rdata_q <= table_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			value_q <= VALUE_BITS'(cmd_data.data);
			addr_q  <= AW'(cmd_data.idx_a);
		end else if (rd_en) begin
			addr_q <= rd_addr;
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_cumulative_interval_search_core.sv =====
// Testbench for cumulative_interval_search_core: table writes and interval searches checked
// against a shadow table and an in-order queue of predicted answers.
// Depends on cis_pkg and the core RTL only.
module tb_cumulative_interval_search_core;
	import cis_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH           = DEF_TABLE_DEPTH;
	localparam int ITEMS_PER_PHASE = 475;
	localparam int CYCLE_LIMIT     = 10000000;
	localparam int TAIL_CYCLES     = 64;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	cis_req_t req_data  = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	cis_res_t res_data;

	cumulative_interval_search_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

	always #2 clk = ~clk;

	cis_req_t  pending_beats[$];
	cis_res_t  search_answers[$];
	cis_res_t  want;
	bit [31:0] shadow_cdf[DEPTH];
	bit [31:0] gen_cdf[DEPTH];
	bit        gen_written[DEPTH];
	int        errors      = 0;
	int        cycles      = 0;
	int        phase_items = 0;
	int        last_base   = 0;
	int        last_n      = 2;
	int        snd_pct     = 0;
	int        rcv_pct     = 0;
	int        snd_calm    = 0;
	int        rcv_calm    = 0;

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("ERROR %s: got %0h exp %0h (cycle %0d)", what, got, exp_val, cycles);
		errors++;
	endtask

	// first index after lo whose entry exceeds the value; not found on any rejection
	function automatic cis_res_t interval_lookup(cis_req_t r);
		cis_res_t res;
		bit       hit;
		int       j;
		res = '0;
		hit = 1'b0;
		if (r.low_bound < DEPTH && r.high_bound < DEPTH && r.low_bound < r.high_bound &&
		    shadow_cdf[r.high_bound] != 0 && r.search_value < shadow_cdf[r.high_bound]) begin
			for (j = r.low_bound + 1; j <= r.high_bound && !hit; j++) begin
				if (r.search_value < shadow_cdf[j]) begin
					hit = 1'b1;
					res.found = 1'b1;
					res.position = j[9:0];
				end
			end
		end
		return res;
	endfunction

	task automatic note_accept(cis_req_t r);
		if (r.req_type == REQ_WRITE) begin
			if (r.entry_index < DEPTH)
				shadow_cdf[r.entry_index] = r.entry_value;
		end else begin
			search_answers.push_back(interval_lookup(r));
		end
	endtask

	// searches may only touch entries already written
	function automatic bit span_ready(int lo, int hi);
		int k;
		if (lo >= hi)
			return gen_written[lo] && gen_written[hi];
		for (k = lo; k <= hi; k++)
			if (!gen_written[k])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic push_write(int idx, bit [31:0] val);
		cis_req_t r;
		r.req_type     = REQ_WRITE;
		r.entry_index  = idx[9:0];
		r.entry_value  = val;
		r.search_value = $urandom;
		r.low_bound    = 10'($urandom);
		r.high_bound   = 10'($urandom);
		gen_cdf[idx]     = val;
		gen_written[idx] = 1'b1;
		pending_beats.push_back(r);
		phase_items++;
	endtask

	task automatic push_search(bit [31:0] val, int lo, int hi);
		cis_req_t r;
		r.req_type     = REQ_SEARCH;
		r.entry_index  = 10'($urandom);
		r.entry_value  = $urandom;
		r.search_value = val;
		r.low_bound    = lo[9:0];
		r.high_bound   = hi[9:0];
		pending_beats.push_back(r);
		phase_items++;
	endtask

	function automatic bit [31:0] pick_value(int lo, int hi);
		int        k;
		bit [31:0] b;
		k = (lo < hi) ? $urandom_range(hi, lo) : $urandom_range(lo, hi);
		b = (gen_written[k]) ? gen_cdf[k] : gen_cdf[hi];
		case ($urandom_range(7))
			0: return b;
			1: return b - 1;
			2: return b + 1;
			3: return 32'h0;
			4: return 32'hFFFF_FFFF;
			5: return $urandom;
			6: return gen_cdf[hi];
			default: return gen_cdf[hi] - 1;
		endcase
	endfunction

	task automatic directed_items();
		// small nondecreasing table with repeats and leading zeros
		push_write(0, 32'h0000_0000);
		push_write(1, 32'h0000_0000);
		push_write(2, 32'h0000_8000);
		push_write(3, 32'h0001_0000);
		push_write(4, 32'h0001_0000);
		push_write(5, 32'h0002_0000);
		push_write(6, 32'h8000_0000);
		push_write(7, 32'hFFFF_FFFF);
		push_search(32'h0000_0000, 0, 7);
		push_search(32'h0000_8000, 0, 7);   // equal to an entry goes one further
		push_search(32'h0001_0000, 2, 7);
		push_search(32'hFFFF_FFFF, 0, 7);   // at total
		push_search(32'hFFFF_FFFE, 5, 7);
		push_search(32'h0000_0000, 0, 1);   // zero total
		push_search(32'h0000_0001, 3, 3);   // empty range
		push_search(32'h0000_0001, 7, 3);   // reversed range
		push_write(1023, 32'hFFFF_FFFF);
		push_write(1022, 32'h0000_0000);
		push_search(32'h0000_0000, 1022, 1023);  // adjacent bounds
		push_search(32'hFFFF_FFFF, 1022, 1023);
		push_search(32'h0000_0000, 1023, 0);
		// unordered region
		push_write(9, 32'h0000_0100);
		push_write(10, 32'h0000_0050);
		push_write(11, 32'h0000_0200);
		push_write(8, 32'h0000_0300);
		push_search(32'h0000_0060, 8, 11);
		push_search(32'h0000_0150, 8, 11);
		last_base = 0;
		last_n    = 12;
	endtask

	task automatic run_episode();
		bit [31:0] ep_vals[256];
		bit [32:0] acc;
		bit [31:0] mask;
		bit        unord;
		bit        down;
		int        n;
		int        base;
		int        lz;
		int        k;
		int        t;
		int        lo;
		int        hi;
		t = $urandom_range(99);
		n = (t < 80) ? $urandom_range(12, 2) : (t < 95) ? $urandom_range(60, 13)
		                                                 : $urandom_range(250, 61);
		base  = $urandom_range(DEPTH - n, 0);
		unord = ($urandom_range(9) == 0);
		down  = ($urandom_range(3) == 0);
		lz    = ($urandom_range(3) == 0) ? $urandom_range(n - 1, 1) : 0;
		case ($urandom_range(3))
			0: mask = 32'h0000_00FF;
			1: mask = 32'h0000_FFFF;
			2: mask = 32'h00FF_FFFF;
			default: mask = 32'hFFFF_FFFF;
		endcase
		acc = ($urandom_range(1) && lz == 0) ? {1'b0, $urandom & mask} : 33'h0;
		for (k = 0; k < n; k++) begin
			if (k < lz) begin
				ep_vals[k] = 32'h0;
			end else if (unord) begin
				ep_vals[k] = $urandom & mask;
			end else begin
				if ($urandom_range(4) != 0)
					acc = acc + {1'b0, $urandom & mask};
				if (acc[32])
					acc = 33'h0_FFFF_FFFF;
				ep_vals[k] = acc[31:0];
			end
		end
		for (k = 0; k < n; k++)
			if (down)
				push_write(base + n - 1 - k, ep_vals[n - 1 - k]);
			else
				push_write(base + k, ep_vals[k]);
		for (k = $urandom_range(7, 2); k > 0; k--) begin
			lo = $urandom_range(base + n - 1, base);
			hi = $urandom_range(base + n - 1, base);
			if (lo > hi && $urandom_range(9) != 0) begin
				t  = lo;
				lo = hi;
				hi = t;
			end
			push_search(pick_value(lo, hi), lo, hi);
		end
		last_base = base;
		last_n    = n;
	endtask

	task automatic run_noise();
		int lo;
		int hi;
		int idx;
		case ($urandom_range(3))
			0: push_write($urandom_range(DEPTH - 1), $urandom);
			1: begin
				idx = $urandom_range(last_base + last_n - 1, last_base);
				push_write(idx, gen_cdf[idx] + $urandom_range(3));
			end
			default: begin
				lo = $urandom_range(DEPTH - 1);
				hi = $urandom_range(DEPTH - 1);
				if (!span_ready(lo, hi)) begin
					lo = $urandom_range(last_base + last_n - 1, last_base);
					hi = $urandom_range(last_base + last_n - 1, last_base);
				end
				push_search($urandom_range(1) ? $urandom : pick_value(lo, hi), lo, hi);
			end
		endcase
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
		end else begin
			if (req_valid && req_ready)
				note_accept(req_data);
			if (!req_valid || req_ready) begin
				if (snd_calm > 0)
					snd_calm--;
				else if ($urandom_range(63) == 0)
					snd_calm = $urandom_range(60, 10);
				if (pending_beats.size() != 0 &&
				    (snd_calm > 0 || $urandom_range(99) >= snd_pct)) begin
					req_valid <= 1'b1;
					req_data  <= pending_beats.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (search_answers.size() == 0) begin
					flag_mismatch("result beat with no search pending", 32'(res_data), 0);
				end else begin
					want = search_answers.pop_front();
					if (res_data.found !== want.found)
						flag_mismatch("found", 32'(res_data.found), 32'(want.found));
					if (res_data.position !== want.position)
						flag_mismatch("position", 32'(res_data.position),
						              32'(want.position));
				end
			end
			if (rcv_calm > 0)
				rcv_calm--;
			else if ($urandom_range(63) == 0)
				rcv_calm = $urandom_range(60, 10);
			res_ready <= (rcv_calm > 0 || $urandom_range(99) >= rcv_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int ph;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_pct = 0;  rcv_pct = 0;  end
				1: begin snd_pct = 76; rcv_pct = 0;  end
				2: begin snd_pct = 0;  rcv_pct = 76; end
				default: begin snd_pct = 24; rcv_pct = 24; end
			endcase
			phase_items = 0;
			if (ph == 0)
				directed_items();
			while (phase_items < ITEMS_PER_PHASE)
				if ($urandom_range(99) < 75)
					run_episode();
				else
					run_noise();
			if (ph == 0) begin
				repeat (5) @(posedge clk);
				arst_n <= 1'b1;
			end
			// sample away from the driving edge so valid and the queues have settled
			while (pending_beats.size() != 0 || req_valid || search_answers.size() != 0)
				@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (search_answers.size() != 0)
			flag_mismatch("searches left unanswered", search_answers.size(), 0);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
